// ===== rtl/dltq_pkg.sv =====
// Shared types and constants of the delta-list timer queue.
// Used by dltq_alu, dltq_ctrl and the top level; depends on nothing.

package dltq_pkg;

	// Defaults for the top-level parameters.
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int KEY_BITS_DEF    = 8;

	// Fixed field widths of the item channels.
	localparam int DELTA_W = 16;
	localparam int KEY_W   = 8;

	// At most this many entries fire on one tick.
	localparam int MAX_FIRE = 16;
	localparam int FIRE_W   = $clog2(MAX_FIRE + 1);

	typedef enum logic [1:0] {
		OP_SOL_SCHED   = 2'd0,
		OP_PLAIN_SCHED = 2'd1,
		OP_CANCEL      = 2'd2,
		OP_TICK        = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STAT_DONE    = 3'd0,
		STAT_IGNORED = 3'd1,
		STAT_FULL    = 3'd2,
		STAT_FIRED   = 3'd3,
		STAT_NONE    = 3'd4
	} status_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_F_RD,
		S_F_CMP,
		S_DECIDE,
		S_R_RD,
		S_R_WR,
		S_I_RD,
		S_I_CMP,
		S_I_SUB,
		S_U_RD,
		S_U_WR,
		S_T_RD,
		S_T_CMP,
		S_T_SUB,
		S_FIRE_OUT,
		S_DONE_OUT
	} seq_state_t;

	// One accepted input item.
	typedef struct packed {
		op_t                op;
		logic [KEY_W-1:0]   key;
		logic [DELTA_W-1:0] delay;
		logic [DELTA_W-1:0] ticks;
	} cmd_t;

	// One result item.
	typedef struct packed {
		status_t          status;
		logic [KEY_W-1:0] key;
		logic             sol;
		logic             last;
	} res_t;

endpackage

// ===== rtl/dltq_mem.sv =====
// Entry memory of the timer queue: one write port, one read port with
// registered read data. Depends on nothing.

module dltq_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 25
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/dltq_alu.sv =====
// Shared adder/subtractor of the timer queue, with carry out and a
// saturated 16-bit view of the sum. Depends on dltq_pkg.

module dltq_alu
	import dltq_pkg::*;
#(
	parameter int AW = 20
) (
	input  alu_op_t            op,
	input  logic [AW-1:0]      a,
	input  logic [AW-1:0]      b,
	output logic [AW-1:0]      res,
	output logic               carry,
	output logic [DELTA_W-1:0] sat
);

	logic [AW:0] full;

	// One add or subtract; for a subtract the carry is the borrow (a < b).
	always_comb begin
		if (op == ALU_ADD) begin
			full = {1'b0, a} + {1'b0, b};
		end else begin
			full = {1'b0, a} - {1'b0, b};
		end
	end

	assign res   = full[AW-1:0];
	assign carry = full[AW];

	// Clamp a sum to the delta range.
	assign sat = (|full[AW:DELTA_W]) ? {DELTA_W{1'b1}} : full[DELTA_W-1:0];

endmodule

// ===== rtl/dltq_ctrl.sv =====
// Sequencer of the timer queue: walks the entry memory one entry at a time
// and drives the shared ALU. Depends on dltq_pkg.

module dltq_ctrl
	import dltq_pkg::*;
#(
	parameter int DEPTH    = QUEUE_DEPTH_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF,
	localparam int IW      = $clog2(DEPTH),
	localparam int AW      = DELTA_W + IW,
	localparam int EW      = KEY_BITS + 1 + DELTA_W
) (
	input  logic               clk,
	input  logic               arst_n,
	// Command side.
	input  logic               cmd_valid,
	input  cmd_t               cmd,
	output logic               cmd_ready,
	// Result side.
	output logic               res_valid,
	output res_t               res,
	input  logic               res_ready,
	// Entry memory.
	output logic               rd_en,
	output logic [IW-1:0]      rd_addr,
	input  logic [EW-1:0]      rd_data,
	output logic               wr_en,
	output logic [IW-1:0]      wr_addr,
	output logic [EW-1:0]      wr_data,
	// Shared ALU.
	output alu_op_t            alu_op,
	output logic [AW-1:0]      alu_a,
	output logic [AW-1:0]      alu_b,
	input  logic [AW-1:0]      alu_res,
	input  logic               alu_carry,
	input  logic [DELTA_W-1:0] alu_sat
);

	localparam int LW = $clog2(DEPTH + 1);

	// Control state.
	seq_state_t          state_q, state_d;
	logic [LW-1:0]       len_q, len_d;
	logic [FIRE_W-1:0]   nfire_q, nfire_d;

	// Working registers of the current item.
	op_t                 op_q, op_d;
	logic [KEY_BITS-1:0] key_q, key_d;
	logic [DELTA_W-1:0]  delay_q, delay_d;
	logic [DELTA_W-1:0]  ticks_q, ticks_d;
	logic [LW-1:0]       idx_q, idx_d;
	logic [LW-1:0]       pos_q, pos_d;
	logic [AW-1:0]       abs_q, abs_d;
	logic                found_q, found_d;
	logic                fsol_q, fsol_d;
	logic [DELTA_W-1:0]  rem_q, rem_d;
	logic [KEY_BITS-1:0] pend_key_q, pend_key_d;
	logic                pend_sol_q, pend_sol_d;
	res_t                res_q, res_d;

	// Fields of the entry last read.
	logic [KEY_BITS-1:0] rd_key;
	logic                rd_sol;
	logic [DELTA_W-1:0]  rd_delta;
	logic [LW-1:0]       idx_nx;
	logic [LW-1:0]       idx_pv;

	assign rd_key   = rd_data[EW-1 -: KEY_BITS];
	assign rd_sol   = rd_data[DELTA_W];
	assign rd_delta = rd_data[DELTA_W-1:0];
	assign idx_nx   = idx_q + LW'(1);
	assign idx_pv   = idx_q - LW'(1);

	assign res       = res_q;
	assign res_valid = (state_q == S_FIRE_OUT) || (state_q == S_DONE_OUT);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
			nfire_q <= '0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			nfire_q <= nfire_d;
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		op_q       <= op_d;
		key_q      <= key_d;
		delay_q    <= delay_d;
		ticks_q    <= ticks_d;
		idx_q      <= idx_d;
		pos_q      <= pos_d;
		abs_q      <= abs_d;
		found_q    <= found_d;
		fsol_q     <= fsol_d;
		rem_q      <= rem_d;
		pend_key_q <= pend_key_d;
		pend_sol_q <= pend_sol_d;
		res_q      <= res_d;
	end

	// Next state, memory and ALU control.
	always_comb begin
		state_d    = state_q;
		len_d      = len_q;
		nfire_d    = nfire_q;
		op_d       = op_q;
		key_d      = key_q;
		delay_d    = delay_q;
		ticks_d    = ticks_q;
		idx_d      = idx_q;
		pos_d      = pos_q;
		abs_d      = abs_q;
		found_d    = found_q;
		fsol_d     = fsol_q;
		rem_d      = rem_q;
		pend_key_d = pend_key_q;
		pend_sol_d = pend_sol_q;
		res_d      = res_q;
		cmd_ready  = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = idx_q[IW-1:0];
		wr_en      = 1'b0;
		wr_addr    = idx_q[IW-1:0];
		wr_data    = rd_data;
		alu_op     = ALU_ADD;
		alu_a      = '0;
		alu_b      = '0;

		unique case (state_q)
			// Wait for an item and latch it.
			S_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					op_d    = cmd.op;
					key_d   = KEY_BITS'(cmd.key);
					delay_d = cmd.delay;
					ticks_d = cmd.ticks;
					idx_d   = '0;
					abs_d   = '0;
					found_d = 1'b0;
					fsol_d  = 1'b0;
					rem_d   = '0;
					nfire_d = '0;
					state_d = (cmd.op == OP_TICK) ? S_T_RD : S_F_RD;
				end
			end

			// Search for the key, summing deltas into its absolute time.
			S_F_RD: begin
				if (idx_q < len_q) begin
					rd_en   = 1'b1;
					state_d = S_F_CMP;
				end else begin
					state_d = S_DECIDE;
				end
			end

			S_F_CMP: begin
				alu_op = ALU_ADD;
				alu_a  = abs_q;
				alu_b  = AW'(rd_delta);
				abs_d  = alu_res;
				if (rd_key == key_q) begin
					found_d = 1'b1;
					fsol_d  = rd_sol;
					rem_d   = rd_delta;
					state_d = S_DECIDE;
				end else begin
					idx_d   = idx_nx;
					state_d = S_F_RD;
				end
			end

			// Pick the path; the ALU checks delay against the absolute time.
			S_DECIDE: begin
				alu_op = ALU_SUB;
				alu_a  = AW'(delay_q);
				alu_b  = abs_q;
				if (op_q == OP_CANCEL) begin
					if (found_q) begin
						state_d = S_R_RD;
					end else begin
						res_d   = '{STAT_IGNORED, KEY_W'(key_q), 1'b0, 1'b1};
						state_d = S_DONE_OUT;
					end
				end else if (found_q) begin
					if (op_q == OP_SOL_SCHED && (fsol_q || !alu_carry)) begin
						res_d   = '{STAT_IGNORED, KEY_W'(key_q), 1'b0, 1'b1};
						state_d = S_DONE_OUT;
					end else begin
						state_d = S_R_RD;
					end
				end else if (len_q == LW'(DEPTH)) begin
					res_d   = '{STAT_FULL, KEY_W'(key_q), 1'b0, 1'b1};
					state_d = S_DONE_OUT;
				end else begin
					idx_d   = '0;
					state_d = S_I_RD;
				end
			end

			// Remove the entry at idx: shift the tail down one place and
			// fold the removed delta into the following entry.
			S_R_RD: begin
				rd_addr = idx_nx[IW-1:0];
				if (idx_nx < len_q) begin
					rd_en   = 1'b1;
					state_d = S_R_WR;
				end else begin
					len_d = len_q - LW'(1);
					priority case (op_q)
						OP_TICK: begin
							state_d = S_T_RD;
						end
						OP_CANCEL: begin
							res_d   = '{STAT_DONE, KEY_W'(key_q), 1'b0, 1'b1};
							state_d = S_DONE_OUT;
						end
						default: begin
							idx_d   = '0;
							state_d = S_I_RD;
						end
					endcase
				end
			end

			S_R_WR: begin
				alu_op  = ALU_ADD;
				alu_a   = AW'(rd_delta);
				alu_b   = AW'(rem_q);
				wr_en   = 1'b1;
				wr_data = {rd_key, rd_sol, alu_sat};
				rem_d   = '0;
				idx_d   = idx_nx;
				state_d = S_R_RD;
			end

			// Find the insertion point, consuming the delay entry by entry.
			S_I_RD: begin
				if (idx_q < len_q) begin
					rd_en   = 1'b1;
					state_d = S_I_CMP;
				end else begin
					pos_d   = idx_q;
					idx_d   = len_q;
					state_d = S_U_RD;
				end
			end

			S_I_CMP: begin
				alu_op = ALU_SUB;
				alu_a  = AW'(delay_q);
				alu_b  = AW'(rd_delta);
				if (alu_carry) begin
					state_d = S_I_SUB;
				end else begin
					delay_d = alu_res[DELTA_W-1:0];
					idx_d   = idx_nx;
					state_d = S_I_RD;
				end
			end

			// The entry at the insertion point keeps only the remainder.
			S_I_SUB: begin
				alu_op  = ALU_SUB;
				alu_a   = AW'(rd_delta);
				alu_b   = AW'(delay_q);
				wr_en   = 1'b1;
				wr_data = {rd_key, rd_sol, alu_res[DELTA_W-1:0]};
				pos_d   = idx_q;
				idx_d   = len_q;
				state_d = S_U_RD;
			end

			// Shift the tail up one place, then write the new entry.
			S_U_RD: begin
				rd_addr = idx_pv[IW-1:0];
				if (idx_q > pos_q) begin
					rd_en   = 1'b1;
					state_d = S_U_WR;
				end else begin
					wr_en   = 1'b1;
					wr_addr = pos_q[IW-1:0];
					wr_data = {key_q, op_q == OP_SOL_SCHED, delay_q};
					len_d   = len_q + LW'(1);
					res_d   = '{STAT_DONE, KEY_W'(key_q), 1'b0, 1'b1};
					state_d = S_DONE_OUT;
				end
			end

			S_U_WR: begin
				wr_en   = 1'b1;
				idx_d   = idx_pv;
				state_d = S_U_RD;
			end

			// Tick: look at the head entry.
			S_T_RD: begin
				rd_addr = '0;
				if (len_q == '0) begin
					if (nfire_q == '0) begin
						res_d = '{STAT_NONE, KEY_W'(key_q), 1'b0, 1'b1};
					end else begin
						res_d = '{STAT_FIRED, KEY_W'(pend_key_q), pend_sol_q, 1'b1};
					end
					state_d = S_DONE_OUT;
				end else begin
					rd_en   = 1'b1;
					state_d = S_T_CMP;
				end
			end

			// The head fires when its delta fits in the remaining ticks. The
			// previous fire is sent only now, since only now is it known
			// whether it is the last one.
			S_T_CMP: begin
				alu_op  = ALU_SUB;
				alu_a   = AW'(ticks_q);
				alu_b   = AW'(rd_delta);
				wr_addr = '0;
				if (alu_carry) begin
					state_d = S_T_SUB;
				end else if (nfire_q == FIRE_W'(MAX_FIRE)) begin
					wr_en   = 1'b1;
					wr_data = {rd_key, rd_sol, {DELTA_W{1'b0}}};
					res_d   = '{STAT_FIRED, KEY_W'(pend_key_q), pend_sol_q, 1'b1};
					state_d = S_DONE_OUT;
				end else begin
					ticks_d    = alu_res[DELTA_W-1:0];
					pend_key_d = rd_key;
					pend_sol_d = rd_sol;
					nfire_d    = nfire_q + FIRE_W'(1);
					idx_d      = '0;
					rem_d      = '0;
					if (nfire_q != '0) begin
						res_d   = '{STAT_FIRED, KEY_W'(pend_key_q), pend_sol_q, 1'b0};
						state_d = S_FIRE_OUT;
					end else begin
						state_d = S_R_RD;
					end
				end
			end

			// Head stays: reduce its delta and close the item.
			S_T_SUB: begin
				alu_op  = ALU_SUB;
				alu_a   = AW'(rd_delta);
				alu_b   = AW'(ticks_q);
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = {rd_key, rd_sol, alu_res[DELTA_W-1:0]};
				if (nfire_q == '0) begin
					res_d = '{STAT_NONE, KEY_W'(key_q), 1'b0, 1'b1};
				end else begin
					res_d = '{STAT_FIRED, KEY_W'(pend_key_q), pend_sol_q, 1'b1};
				end
				state_d = S_DONE_OUT;
			end

			// A fire that is not the last; then remove the head.
			S_FIRE_OUT: begin
				if (res_ready) begin
					state_d = S_R_RD;
				end
			end

			// The last result of the item.
			S_DONE_OUT: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
		endcase
	end

	// The queue never holds more than its depth.
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(DEPTH))
		else $error("queue length beyond depth");

	// The length moves by at most one entry per step.
	a_len_step: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q != $past(len_q)) |->
		(len_q == $past(len_q) + LW'(1) || len_q == $past(len_q) - LW'(1)))
		else $error("queue length jumped");

	// An insertion only runs with a free slot.
	a_no_insert_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_U_RD || state_q == S_U_WR) |-> (len_q < LW'(DEPTH)))
		else $error("insertion into a full queue");

	// No tick fires more than the limit.
	a_fire_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nfire_q <= FIRE_W'(MAX_FIRE))
		else $error("too many fires in one tick");

	// The memory is left alone between items.
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !wr_en)
		else $error("memory write while idle");

endmodule

// ===== rtl/delta_list_timer_queue.sv =====
// Top level of the delta-list timer queue: stream ports, item unpacking and
// the output register. Depends on dltq_pkg, dltq_mem, dltq_alu, dltq_ctrl.
//
// Channel   Direction  Handshake          Content
// s_*       in         s_tvalid/s_tready  one operation on the queue
// m_*       out        m_tvalid/m_tready  one result, m_tlast on the last one
//
// Every queue entry visited is read, then used, through the memory read
// port and the shared ALU. s_tready is low while an item is being worked;
// the output register lets the next item in while the last result still
// waits. A stalled m_tready holds the sequencer at its next result. Reset
// empties the queue at once; no clearing pass is needed.

module delta_list_timer_queue
	import dltq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int KEY_BITS    = KEY_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // entry_key[7:0], delay_ticks[23:8], elapsed_ticks[39:24]
	input  logic [1:0]  s_tuser,   // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // fired_key[7:0]
	output logic [3:0]  m_tuser,   // status[2:0], was_solicited[3]
	output logic        m_tlast    // last_result
);

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int AW = DELTA_W + IW;
	localparam int EW = KEY_BITS + 1 + DELTA_W;

	cmd_t               cmd;
	logic               cmd_ready;
	logic               res_valid;
	res_t               res;
	logic               res_ready;
	logic               rd_en;
	logic [IW-1:0]      rd_addr;
	logic [EW-1:0]      rd_data;
	logic               wr_en;
	logic [IW-1:0]      wr_addr;
	logic [EW-1:0]      wr_data;
	alu_op_t            alu_op;
	logic [AW-1:0]      alu_a;
	logic [AW-1:0]      alu_b;
	logic [AW-1:0]      alu_res;
	logic               alu_carry;
	logic [DELTA_W-1:0] alu_sat;
	logic               out_valid_q;
	res_t               out_q;

	// Unpack the input item.
	always_comb begin
		cmd.op    = op_t'(s_tuser);
		cmd.key   = s_tdata[7:0];
		cmd.delay = s_tdata[23:8];
		cmd.ticks = s_tdata[39:24];
	end

	assign s_tready = cmd_ready;

	// Output register: refilled whenever it is empty or being drained.
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.key;
	assign m_tuser  = {out_q.sol, out_q.status};
	assign m_tlast  = out_q.last;

	dltq_mem #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH (EW)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	dltq_alu #(
		.AW (AW)
	) u_alu (
		.op    (alu_op),
		.a     (alu_a),
		.b     (alu_b),
		.res   (alu_res),
		.carry (alu_carry),
		.sat   (alu_sat)
	);

	dltq_ctrl #(
		.DEPTH    (QUEUE_DEPTH),
		.KEY_BITS (KEY_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (s_tvalid),
		.cmd       (cmd),
		.cmd_ready (cmd_ready),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.alu_op    (alu_op),
		.alu_a     (alu_a),
		.alu_b     (alu_b),
		.alu_res   (alu_res),
		.alu_carry (alu_carry),
		.alu_sat   (alu_sat)
	);

endmodule
